@@ design/cesd_pkg.sv @@
`timescale 1ns / 1ps

package cesd_pkg;

    // Default width of the running decoded-length counter.
    localparam int unsigned LENGTH_BITS_DEF = 16;

    // Width of the decoded-length field on the result port.
    localparam int unsigned LEN_FIELD_BITS = 16;

    // Characters that take part in escape decoding.
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LC_A      = 8'h61;
    localparam logic [7:0] CH_LC_F      = 8'h66;
    localparam logic [7:0] CH_UC_A      = 8'h41;
    localparam logic [7:0] CH_UC_F      = 8'h46;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NUL       = 8'h00;

    // One decoded byte waiting in the result buffer.
    typedef struct packed {
        logic [7:0]                out_byte;
        logic                      run_last;
        logic                      string_done;
        logic [LEN_FIELD_BITS-1:0] decoded_length;
    } t_result;

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [7:0] diff;
        logic [4:0] res;
        res  = 5'd0;
        diff = 8'd0;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            diff = b - CH_ZERO;
            res  = {1'b1, diff[3:0]};
        end else if (b >= CH_LC_A && b <= CH_LC_F) begin
            diff = b - CH_LC_A + 8'd10;
            res  = {1'b1, diff[3:0]};
        end else if (b >= CH_UC_A && b <= CH_UC_F) begin
            diff = b - CH_UC_A + 8'd10;
            res  = {1'b1, diff[3:0]};
        end
        return res;
    endfunction

endpackage

@@ design/c_escape_string_decoder.sv @@
`timescale 1ns / 1ps

// Streaming C-string escape decoder. Raw string bytes enter one beat at a time, with
// i_end_of_string set on the final byte, and decoded bytes leave one beat at a time, each
// with a running, saturating decoded length. An input byte is decoded in the cycle it is
// accepted and its zero, one or two results are written into a four-entry result buffer;
// the output shows the entry at the buffer head. The input takes one byte per cycle while
// the buffer has two free entries; the single output port drains one result per cycle
// while i_ready is high, so an input that yields two results (a short hex escape or a
// bare \x followed by text) adds to the buffer fill and can hold the input back.
module c_escape_string_decoder #(
    parameter int unsigned LENGTH_BITS = cesd_pkg::LENGTH_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [7:0]                          i_in_byte,
    input  logic                                i_end_of_string,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [7:0]                          o_out_byte,
    output logic                                o_run_last,
    output logic                                o_string_done,
    output logic [cesd_pkg::LEN_FIELD_BITS-1:0] o_decoded_length
);

    import cesd_pkg::*;

    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_ESC   = 2'd1,
        PH_HEX0  = 2'd2,
        PH_HEX1  = 2'd3
    } t_phase;

    localparam int unsigned BUF_DEPTH = 4;
    localparam int unsigned PTR_BITS  = $clog2(BUF_DEPTH);
    localparam int unsigned CNT_BITS  = $clog2(BUF_DEPTH + 1);
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    t_phase                 r_phase, n_phase;
    logic [3:0]             r_hex, n_hex;
    logic [LENGTH_BITS-1:0] r_len, n_len;

    t_result                r_buf [BUF_DEPTH];
    logic [PTR_BITS-1:0]    r_head;
    logic [PTR_BITS-1:0]    r_tail;
    logic [CNT_BITS-1:0]    r_count;

    logic                   in_acc;
    logic                   out_acc;
    logic [4:0]             hex_in;
    logic                   plain_esc;
    logic                   em0_v, em1_v;
    logic [7:0]             em0_b, em1_b;
    logic [7:0]             esc_b;
    logic [LENGTH_BITS-1:0] len_1, len_2;
    logic [LEN_FIELD_BITS-1:0] len_1_f, len_2_f;
    t_result                res_0, res_1;
    logic [CNT_BITS-1:0]    push_cnt;
    logic [CNT_BITS-1:0]    pop_cnt;

    // Handshake: room for two results keeps the input side independent of the output side.
    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign o_ready = (r_count <= CNT_BITS'(BUF_DEPTH - 2));
    assign o_valid = (r_count != '0);

    assign hex_in    = hex_decode(i_in_byte);
    assign plain_esc = (i_in_byte == CH_BACKSLASH) && !i_end_of_string;

    // Byte given by a simple escape; any other byte stands for itself.
    always_comb begin
        unique case (i_in_byte)
            CH_N:    esc_b = CH_NEWLINE;
            CH_R:    esc_b = CH_RETURN;
            CH_T:    esc_b = CH_TAB;
            CH_ZERO: esc_b = CH_NUL;
            default: esc_b = i_in_byte;
        endcase
    end

    // Escape decode: up to two results per input byte and the next phase.
    always_comb begin
        em0_v   = 1'b0;
        em0_b   = i_in_byte;
        em1_v   = 1'b0;
        em1_b   = i_in_byte;
        n_phase = r_phase;
        n_hex   = r_hex;
        unique case (r_phase)
            PH_PLAIN: begin
                if (plain_esc) begin
                    n_phase = PH_ESC;
                end else begin
                    em0_v   = 1'b1;
                    n_phase = PH_PLAIN;
                end
            end
            PH_ESC: begin
                n_phase = PH_PLAIN;
                if (i_in_byte == CH_X && !i_end_of_string) begin
                    n_phase = PH_HEX0;
                end else begin
                    em0_v = 1'b1;
                    em0_b = esc_b;
                end
            end
            PH_HEX0: begin
                if (hex_in[4]) begin
                    if (i_end_of_string) begin
                        em0_v   = 1'b1;
                        em0_b   = {4'd0, hex_in[3:0]};
                        n_phase = PH_PLAIN;
                    end else begin
                        n_hex   = hex_in[3:0];
                        n_phase = PH_HEX1;
                    end
                end else begin
                    // A bare \x gives 'x', then the byte is handled as plain text.
                    em0_v = 1'b1;
                    em0_b = CH_X;
                    if (plain_esc) begin
                        n_phase = PH_ESC;
                    end else begin
                        em1_v   = 1'b1;
                        n_phase = PH_PLAIN;
                    end
                end
            end
            PH_HEX1: begin
                em0_v = 1'b1;
                if (hex_in[4]) begin
                    em0_b   = {r_hex, hex_in[3:0]};
                    n_phase = PH_PLAIN;
                end else begin
                    // One hex digit gives its value, then the byte is plain text.
                    em0_b = {4'd0, r_hex};
                    if (plain_esc) begin
                        n_phase = PH_ESC;
                    end else begin
                        em1_v   = 1'b1;
                        n_phase = PH_PLAIN;
                    end
                end
            end
            default: begin
                n_phase = PH_PLAIN;
            end
        endcase
        if (i_end_of_string) begin
            n_phase = PH_PLAIN;
        end
    end

    // Saturating length after the first and the second result.
    assign len_1 = (r_len == LEN_MAX) ? r_len : r_len + LENGTH_BITS'(1);
    assign len_2 = (len_1 == LEN_MAX) ? len_1 : len_1 + LENGTH_BITS'(1);

    generate
        if (LENGTH_BITS >= LEN_FIELD_BITS) begin : g_len_trunc
            assign len_1_f = len_1[LEN_FIELD_BITS-1:0];
            assign len_2_f = len_2[LEN_FIELD_BITS-1:0];
        end else begin : g_len_ext
            assign len_1_f = {{(LEN_FIELD_BITS - LENGTH_BITS){1'b0}}, len_1};
            assign len_2_f = {{(LEN_FIELD_BITS - LENGTH_BITS){1'b0}}, len_2};
        end
    endgenerate

    always_comb begin
        if (!in_acc) begin
            n_len = r_len;
        end else if (i_end_of_string) begin
            n_len = '0;
        end else if (em1_v) begin
            n_len = len_2;
        end else if (em0_v) begin
            n_len = len_1;
        end else begin
            n_len = r_len;
        end
    end

    // Result words; the last one of an input carries the run and string flags.
    always_comb begin
        res_0.out_byte       = em0_b;
        res_0.run_last       = !em1_v;
        res_0.string_done    = !em1_v && i_end_of_string;
        res_0.decoded_length = len_1_f;
        res_1.out_byte       = em1_b;
        res_1.run_last       = 1'b1;
        res_1.string_done    = i_end_of_string;
        res_1.decoded_length = len_2_f;
    end

    assign push_cnt = in_acc ? (CNT_BITS'(em0_v) + CNT_BITS'(em1_v)) : '0;
    assign pop_cnt  = CNT_BITS'(out_acc);

    // Decoder state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_hex   <= 4'd0;
            r_len   <= '0;
        end else begin
            if (in_acc) begin
                r_phase <= n_phase;
                r_hex   <= n_hex;
            end
            r_len <= n_len;
        end
    end

    // Result buffer pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= r_head + PTR_BITS'(out_acc);
            r_tail  <= r_tail + push_cnt[PTR_BITS-1:0];
            r_count <= r_count + push_cnt - pop_cnt;
        end
    end

    // Result buffer storage.
    always_ff @(posedge i_clk) begin
        if (in_acc && em0_v) begin
            r_buf[r_tail] <= res_0;
        end
        if (in_acc && em1_v) begin
            r_buf[r_tail + PTR_BITS'(1)] <= res_1;
        end
    end

    assign o_out_byte       = r_buf[r_head].out_byte;
    assign o_run_last       = r_buf[r_head].run_last;
    assign o_string_done    = r_buf[r_head].string_done;
    assign o_decoded_length = r_buf[r_head].decoded_length;

    // The buffer never holds more than its depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(BUF_DEPTH))
        else $error("result buffer overfilled");

    // A string's end resets the length and the phase for the next string.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_end_of_string |=> (r_len == '0) && (r_phase == PH_PLAIN))
        else $error("state not cleared at end of string");

    // The final byte of a string is always the last result of its input.
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_string_done |-> o_run_last)
        else $error("string_done without run_last");

    // A final input byte always produces at least one result.
    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_end_of_string |-> em0_v)
        else $error("end of string produced no result");

endmodule
